// File: rtl/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg - shared definitions for the integer to text formatter
// Widths, character codes, the digit-to-ASCII mapping and the divider
// status bundle.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_WIDTH  = 64;
    localparam int RADIX_BITS = 6;
    localparam int WIDTH_BITS = 7;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = VALUE_BITS / DIV_STEPS;
    localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX = RADIX_BITS'(16);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    typedef struct packed {
        logic                  done;
        logic [RADIX_BITS-1:0] rem;
    } t_div_status;

    function automatic logic [7:0] digit_char(input logic [RADIX_BITS-1:0] d,
                                              input logic lower);
        logic [7:0] dd;
        dd = {{(8-RADIX_BITS){1'b0}}, d};
        if (d < RADIX_BITS'(10)) begin
            digit_char = CH_ZERO + dd;
        end else begin
            digit_char = (lower ? CH_LO_A : CH_UP_A) + dd - 8'd10;
        end
    endfunction

endpackage

// File: rtl/integer_to_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter - printf-style integer to ASCII conversion
// Each digit comes from one division by the radix, reloaded with the quotient
// until it is zero; a setup state then lays out the field before the characters.
// A new number is taken only when idle: busy stays high until the last
// character is issued.
// Characters leave one per cycle on o_strobe; the receiver cannot stall.
// Reset is synchronous and active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_text_formatter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [itf_pkg::VALUE_BITS-1:0] i_value,
    input  logic [itf_pkg::RADIX_BITS-1:0] i_radix,
    input  logic [itf_pkg::WIDTH_BITS-1:0] i_width,
    input  logic                           i_zero_pad,
    input  logic                           i_signed_mode,
    input  logic                           i_plus_sign,
    input  logic                           i_space_sign,
    input  logic                           i_left_align,
    input  logic                           i_alt_prefix,
    input  logic                           i_lower_case,
    output logic                           o_strobe,
    output logic [7:0]                     o_text_char,
    output logic                           o_last_char
);
    import itf_pkg::*;

    localparam int DIG_DEPTH = VALUE_BITS;
    localparam int IDX_BITS  = $clog2(DIG_DEPTH);
    localparam int ND_BITS   = $clog2(DIG_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [2:0] PH_LPAD = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_PFX0 = 3'd2;
    localparam logic [2:0] PH_PFXX = 3'd3;
    localparam logic [2:0] PH_ZPAD = 3'd4;
    localparam logic [2:0] PH_DIG  = 3'd5;
    localparam logic [2:0] PH_RPAD = 3'd6;

    function automatic logic [2:0] lowest_phase(input logic [6:0] m);
        lowest_phase = PH_DIG;
        for (int i = 6; i >= 0; i--) begin
            if (m[i]) lowest_phase = 3'(i);
        end
    endfunction

    logic [1:0]            r_state;
    logic [2:0]            r_phase;
    logic [6:0]            r_mask;
    logic [WIDTH_BITS-1:0] r_pad;
    logic [WIDTH_BITS-1:0] r_remain;
    logic [ND_BITS-1:0]    r_nd;
    logic [RADIX_BITS-1:0] r_digs [DIG_DEPTH];

    logic [WIDTH_BITS-1:0] r_width;
    logic                  r_zpad;
    logic                  r_left;
    logic                  r_lower;
    logic                  r_has_sign;
    logic [7:0]            r_sign_ch;
    logic [1:0]            r_pre;
    logic [RADIX_BITS-1:0] r_radix;

    logic                  r_strobe;
    logic [7:0]            r_char;
    logic                  r_last;

    logic                  accept;
    logic [RADIX_BITS-1:0] radix_cl;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  div_load;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [RADIX_BITS-1:0] div_divisor;
    logic [VALUE_BITS-1:0] quotient;
    t_div_status           div_st;

    logic [WIDTH_BITS-1:0] total;
    logic [WIDTH_BITS-1:0] pad;
    logic [6:0]            mask;
    logic [IDX_BITS-1:0]   rd_idx;
    logic [7:0]            n_char;
    logic                  phase_end;
    logic [6:0]            above;
    logic [2:0]            n_phase;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        priority if (i_radix < RADIX_MIN) begin
            radix_cl = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_cl = RADIX_MAX;
        end else begin
            radix_cl = i_radix;
        end
    end

    assign neg = i_signed_mode && i_value[VALUE_BITS-1];
    assign mag = neg ? (~i_value + 1'b1) : i_value;

    assign div_load     = accept || ((r_state == ST_DIV) && div_st.done &&
                                     (quotient != '0));
    assign div_dividend = accept ? mag : quotient;
    // inputs may move after the beat, so reloads use the held radix
    assign div_divisor  = accept ? radix_cl : r_radix;

    itf_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quotient),
        .o_status   (div_st)
    );

    // field layout, worked out once all digits are known
    always_comb begin
        total = WIDTH_BITS'(r_nd) + WIDTH_BITS'(r_pre) + WIDTH_BITS'(r_has_sign);
        pad   = (r_width > total) ? (r_width - total) : '0;
        mask[PH_LPAD] = !r_left && !r_zpad && (pad != '0);
        mask[PH_SIGN] = r_has_sign;
        mask[PH_PFX0] = (r_pre != 2'd0);
        mask[PH_PFXX] = (r_pre == 2'd2);
        mask[PH_ZPAD] = !r_left && r_zpad && (pad != '0);
        mask[PH_DIG]  = 1'b1;
        mask[PH_RPAD] = r_left && (pad != '0);
    end

    assign rd_idx = IDX_BITS'(r_nd - 1'b1);

    always_comb begin
        n_char    = CH_SPACE;
        phase_end = 1'b1;
        unique case (r_phase)
            PH_LPAD, PH_RPAD: begin
                n_char    = CH_SPACE;
                phase_end = (r_pad == WIDTH_BITS'(1));
            end
            PH_SIGN: n_char = r_sign_ch;
            PH_PFX0: n_char = CH_ZERO;
            PH_PFXX: n_char = r_lower ? CH_LO_X : CH_UP_X;
            PH_ZPAD: begin
                n_char    = CH_ZERO;
                phase_end = (r_pad == WIDTH_BITS'(1));
            end
            PH_DIG: begin
                n_char    = digit_char(r_digs[rd_idx], r_lower);
                phase_end = (r_nd == ND_BITS'(1));
            end
            default: begin
                n_char    = CH_SPACE;
                phase_end = 1'b1;
            end
        endcase
    end

    assign above   = (7'h7f << r_phase) << 1;
    assign n_phase = lowest_phase(r_mask & above);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_nd     <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_nd    <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        r_nd <= r_nd + 1'b1;
                        if (quotient == '0) r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_phase == PH_DIG) r_nd <= r_nd - 1'b1;
                    if (r_remain == WIDTH_BITS'(1)) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_width    <= (i_width > WIDTH_BITS'(MAX_WIDTH)) ?
                          WIDTH_BITS'(MAX_WIDTH) : i_width;
            r_zpad     <= i_zero_pad && !i_left_align;
            r_left     <= i_left_align;
            r_lower    <= i_lower_case;
            r_has_sign <= neg || i_plus_sign || i_space_sign;
            r_sign_ch  <= neg ? CH_MINUS : (i_plus_sign ? CH_PLUS : CH_SPACE);
            r_pre      <= !i_alt_prefix ? 2'd0 :
                          (radix_cl == RADIX_HEX) ? 2'd2 :
                          (radix_cl == RADIX_OCT) ? 2'd1 : 2'd0;
            r_radix    <= radix_cl;
        end
        if ((r_state == ST_DIV) && div_st.done) begin
            r_digs[r_nd[IDX_BITS-1:0]] <= div_st.rem;
        end
        if (r_state == ST_PREP) begin
            r_mask   <= mask;
            r_pad    <= pad;
            r_remain <= pad + total;
            r_phase  <= lowest_phase(mask);
        end
        if (r_state == ST_EMIT) begin
            r_char   <= n_char;
            r_last   <= (r_remain == WIDTH_BITS'(1));
            r_remain <= r_remain - 1'b1;
            if ((r_phase == PH_LPAD) || (r_phase == PH_ZPAD) || (r_phase == PH_RPAD)) begin
                r_pad <= r_pad - 1'b1;
            end
            if (phase_end) r_phase <= n_phase;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

// File: rtl/itf_div_unit.sv
// ----------------------------------------------------------------------------
// itf_div_unit - iterative unsigned divider
// Restoring division of a VALUE_BITS dividend by a small radix, DIV_STEPS
// quotient bits per cycle; pulses done with quotient and remainder.
// ----------------------------------------------------------------------------
module itf_div_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [itf_pkg::VALUE_BITS-1:0]     i_dividend,
    input  logic [itf_pkg::RADIX_BITS-1:0]     i_divisor,
    output logic [itf_pkg::VALUE_BITS-1:0]     o_quotient,
    output itf_pkg::t_div_status               o_status
);
    import itf_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [VALUE_BITS-1:0]   r_acc;
    logic [RADIX_BITS-1:0]   r_rem;
    logic [RADIX_BITS-1:0]   r_div;

    logic [VALUE_BITS-1:0]   n_acc;
    logic [RADIX_BITS-1:0]   n_rem;
    logic [RADIX_BITS:0]     trial;

    // dividend bits shift out the top, quotient bits shift in at the bottom
    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        trial = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {n_rem, n_acc[VALUE_BITS-1]};
            n_acc = {n_acc[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = RADIX_BITS'(trial - {1'b0, r_div});
                n_acc[0] = 1'b1;
            end else begin
                n_rem = trial[RADIX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_quotient    = r_acc;
    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

// File: bench/tb_integer_to_text_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_text_formatter - self-checking bench for the integer formatter
// Sends directed and randomly formatted numbers on the start/busy handshake
// and predicts the text of every field in the bench. Each character beat on
// o_strobe is compared with the oldest predicted character. A watchdog ends
// the run if the handshake goes quiet for too long.
// ----------------------------------------------------------------------------
module tb_integer_to_text_formatter;

    import itf_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TEXT_LIMIT     = 64;

    // formatting flag bits, {zero, signed, plus, space, left, alt, lower}
    localparam logic [6:0] F_NONE  = 7'b0000000;
    localparam logic [6:0] F_ZERO  = 7'b1000000;
    localparam logic [6:0] F_SGN   = 7'b0100000;
    localparam logic [6:0] F_PLUS  = 7'b0010000;
    localparam logic [6:0] F_SPACE = 7'b0001000;
    localparam logic [6:0] F_LEFT  = 7'b0000100;
    localparam logic [6:0] F_ALT   = 7'b0000010;
    localparam logic [6:0] F_LOWER = 7'b0000001;

    localparam logic [RADIX_BITS-1:0] RADIX_BIN = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC = RADIX_BITS'(10);

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
        logic [WIDTH_BITS-1:0] width;
        logic [6:0]            flags;
    } t_fmt_req;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] i_value;
    logic [RADIX_BITS-1:0] i_radix;
    logic [WIDTH_BITS-1:0] i_width;
    logic                  i_zero_pad;
    logic                  i_signed_mode;
    logic                  i_plus_sign;
    logic                  i_space_sign;
    logic                  i_left_align;
    logic                  i_alt_prefix;
    logic                  i_lower_case;
    logic                  o_strobe;
    logic [7:0]            o_text_char;
    logic                  o_last_char;

    t_text_beat expected_text[$];
    int         err_count;
    int         quiet_cycles;
    bit         no_idle;

    string upper_digits = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string lower_digits = "0123456789abcdefghijklmnopqrstuvwxyz";

    integer_to_text_formatter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_width       (i_width),
        .i_zero_pad    (i_zero_pad),
        .i_signed_mode (i_signed_mode),
        .i_plus_sign   (i_plus_sign),
        .i_space_sign  (i_space_sign),
        .i_left_align  (i_left_align),
        .i_alt_prefix  (i_alt_prefix),
        .i_lower_case  (i_lower_case),
        .o_strobe      (o_strobe),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // builds the field text of one number and queues its characters
    function automatic void format_number_text(input t_fmt_req r);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            sign_ch;
        logic [7:0]            digs[0:71];
        logic [7:0]            text[0:159];
        logic [7:0]            dch;
        logic                  zpad;
        logic                  left;
        logic                  lower;
        bit                    has_sign;
        int unsigned           base;
        int unsigned           w;
        int unsigned           nd;
        int unsigned           pre;
        int unsigned           total;
        int unsigned           pad;
        int unsigned           n;
        int unsigned           k;
        t_text_beat            b;

        left  = r.flags[2];
        lower = r.flags[0];
        zpad  = r.flags[6] && !left;
        base  = r.radix;
        if (base < RADIX_MIN) base = RADIX_MIN;
        if (base > RADIX_MAX) base = RADIX_MAX;
        w = r.width;
        if (w > MAX_WIDTH) w = MAX_WIDTH;

        mag      = r.value;
        has_sign = 1'b0;
        sign_ch  = CH_SPACE;
        if (r.flags[5] && r.value[VALUE_BITS-1]) begin
            has_sign = 1'b1;
            sign_ch  = CH_MINUS;
            mag      = ~r.value + 1'b1;
        end else if (r.flags[4]) begin
            has_sign = 1'b1;
            sign_ch  = CH_PLUS;
        end else if (r.flags[3]) begin
            has_sign = 1'b1;
        end

        pre = 0;
        if (r.flags[1]) begin
            if (base == RADIX_HEX) pre = 2;
            else if (base == RADIX_OCT) pre = 1;
        end

        nd = 0;
        if (mag == '0) begin
            digs[0] = CH_ZERO;
            nd      = 1;
        end else begin
            while (mag != '0 && nd < 70) begin
                k        = mag % base;
                digs[nd] = lower ? lower_digits[k] : upper_digits[k];
                mag      = mag / base;
                nd++;
            end
        end

        total = nd + pre + (has_sign ? 1 : 0);
        pad   = (total < w) ? w - total : 0;
        dch   = lower ? lower_digits[33] : upper_digits[33];

        n = 0;
        if (!left && !zpad) begin
            for (k = 0; k < pad; k++) begin
                text[n] = CH_SPACE;
                n++;
            end
        end
        if (has_sign) begin
            text[n] = sign_ch;
            n++;
        end
        if (pre >= 1) begin
            text[n] = CH_ZERO;
            n++;
        end
        if (pre == 2) begin
            text[n] = dch;
            n++;
        end
        if (!left && zpad) begin
            for (k = 0; k < pad; k++) begin
                text[n] = CH_ZERO;
                n++;
            end
        end
        while (nd > 0) begin
            nd--;
            text[n] = digs[nd];
            n++;
        end
        if (left) begin
            for (k = 0; k < pad; k++) begin
                text[n] = CH_SPACE;
                n++;
            end
        end

        if (n > TEXT_LIMIT) n = TEXT_LIMIT;
        for (k = 0; k < n; k++) begin
            b.ch   = text[k];
            b.last = (k + 1 == n);
            expected_text.push_back(b);
        end
    endfunction

    function automatic t_fmt_req make_req(input logic [VALUE_BITS-1:0] value,
                                          input int radix, input int width,
                                          input logic [6:0] flags);
        t_fmt_req r;
        r.value = value;
        r.radix = RADIX_BITS'(radix);
        r.width = WIDTH_BITS'(width);
        r.flags = flags;
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(20);
            1: v = -VALUE_BITS'($urandom_range(1, 20));
            2: begin
                case ($urandom_range(3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    default: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                endcase
            end
            3: v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // send one number beat, idling on start at random until it is taken
    task automatic issue_number(input t_fmt_req r);
        bit sent;
        format_number_text(r);
        i_value       = r.value;
        i_radix       = r.radix;
        i_width       = r.width;
        i_zero_pad    = r.flags[6];
        i_signed_mode = r.flags[5];
        i_plus_sign   = r.flags[4];
        i_space_sign  = r.flags[3];
        i_left_align  = r.flags[2];
        i_alt_prefix  = r.flags[1];
        i_lower_case  = r.flags[0];
        sent          = 1'b0;
        while (!sent) begin
            start = no_idle || ($urandom_range(99) >= 23);
            @(posedge i_clk);
            sent = start && !busy;
            @(negedge i_clk);
        end
        start = 1'b0;
    endtask

    task automatic test_directed_cases();
        issue_number(make_req(32'h0, 10, 0, F_NONE));
        issue_number(make_req(32'h0, 8, 0, F_ALT));
        issue_number(make_req(32'h0, 16, 0, F_ALT | F_LOWER));
        issue_number(make_req(32'hFFFF_FFFF, 16, 12, F_ALT | F_ZERO));
        issue_number(make_req(32'h8000_0000, 10, 0, F_SGN));
        issue_number(make_req(32'h7FFF_FFFF, 10, 15, F_SGN | F_PLUS));
        issue_number(make_req(32'hFFFF_FFFF, 2, 0, F_NONE));
        issue_number(make_req(32'hFFFF_FFFF, 36, 0, F_LOWER));
        // radix outside 2..36 clamps to the nearest end
        issue_number(make_req(32'd12345, 0, 0, F_NONE));
        issue_number(make_req(32'd12345, 1, 0, F_NONE));
        issue_number(make_req(32'd12345, 37, 0, F_NONE));
        issue_number(make_req(32'd12345, 63, 0, F_NONE));
        issue_number(make_req(32'd42, 10, 64, F_ZERO | F_PLUS));
        issue_number(make_req(32'd42, 10, 127, F_LEFT));
        issue_number(make_req(32'd42, 10, 100, F_LEFT | F_ZERO));
        issue_number(make_req(32'd42, 10, 5, F_SPACE));
        issue_number(make_req(32'd42, 10, 0, F_PLUS | F_SPACE));
        issue_number(make_req(32'hFFFF_FFD6, 10, 8, F_SGN | F_SPACE | F_ZERO));
        issue_number(make_req(32'hFFFF_FFD6, 10, 0, F_PLUS));
        issue_number(make_req(32'h1A2B, 16, 10, F_ALT | F_LOWER | F_LEFT));
        issue_number(make_req(32'o755, 8, 6, F_ALT | F_ZERO));
        issue_number(make_req(-32'sd255, 16, 10, F_SGN | F_ALT | F_ZERO));
        issue_number(make_req(32'd999, 10, 3, F_ALT));
        issue_number(make_req(32'h8000_0000, 2, 64, F_SGN | F_PLUS | F_ZERO));
    endtask

    // printf-like requests: mostly common radices and modest widths, plus the extremes
    task automatic test_printf_style(input int count);
        t_fmt_req r;
        int       width;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0: r.radix = RADIX_BIN;
                1: r.radix = RADIX_MAX;
                2, 3: r.radix = RADIX_HEX;
                4: r.radix = RADIX_OCT;
                default: r.radix = RADIX_DEC;
            endcase
            case ($urandom_range(5))
                0: width = 0;
                1: width = MAX_WIDTH;
                default: width = $urandom_range(0, 20);
            endcase
            r.value = pick_value();
            r.width = WIDTH_BITS'(width);
            r.flags = 7'($urandom);
            issue_number(r);
        end
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_printf_style(count);
        no_idle = 1'b0;
    endtask

    // every field over its whole encoding, out-of-range radix and width too
    task automatic test_field_noise(input int count);
        t_fmt_req r;
        for (int i = 0; i < count; i++) begin
            r.value = $urandom;
            r.radix = RADIX_BITS'($urandom);
            r.width = WIDTH_BITS'($urandom);
            r.flags = 7'($urandom);
            issue_number(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_text_beat exp_beat;
        if (i_rst_n && o_strobe) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character beat: text_char %h last_char %b",
                       o_text_char, o_last_char);
                err_count++;
            end else begin
                exp_beat = expected_text.pop_front();
                if (o_text_char !== exp_beat.ch) begin
                    $error("text_char mismatch: expected %h, actual %h",
                           exp_beat.ch, o_text_char);
                    err_count++;
                end
                if (o_last_char !== exp_beat.last) begin
                    $error("last_char mismatch: expected %b, actual %b",
                           exp_beat.last, o_last_char);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        err_count     = 0;
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_value       = '0;
        i_radix       = RADIX_DEC;
        i_width       = '0;
        i_zero_pad    = 1'b0;
        i_signed_mode = 1'b0;
        i_plus_sign   = 1'b0;
        i_space_sign  = 1'b0;
        i_left_align  = 1'b0;
        i_alt_prefix  = 1'b0;
        i_lower_case  = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_printf_style(60);
        test_back_to_back(30);
        test_field_noise(30);
        test_printf_style(30);

        start = 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/itf_pkg.sv
rtl/itf_div_unit.sv
rtl/integer_to_text_formatter.sv
bench/tb_integer_to_text_formatter.sv
